/* rtl/core/cbrd_pkg.sv */
package cbrd_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_NREC, PH_LX, PH_LY, PH_LCNT, PH_XOFF, PH_YOFF, PH_SHORT,
    PH_TYPE, PH_ROWS, PH_RY, PH_COLS, PH_RX, PH_RCNT, PH_NPTS, PH_WIDTH,
    PH_GCNT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_END    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // One command from the parser to the emitter: up to two results.
  typedef struct packed {
    logic        rec;
    logic        cnt_short;
    logic [15:0] short_val;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] cnt;
    logic        tail;
    kind_t       tail_kind;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] cnt;
    logic        last;
  } res_t;

  function automatic logic [31:0] short_to_float(input logic [15:0] v);
    logic [31:0] s;
    logic [15:0] m;
    logic [4:0]  p;
    logic [31:0] sign;
    logic [31:0] ms;
    s = {{16{v[15]}}, v};
    sign = '0;
    m = v;
    p = '0;
    if (v[15]) begin
      sign = 32'h8000_0000;
      m = 16'(-v);
    end
    for (int i = 1; i < 17; i++) begin
      if (i < 17 && (({1'b0, m} >> i) != 17'd0)) begin
        p = 5'(i);
      end
    end
    ms = {16'd0, m} << (5'd23 - p);
    if (s == 32'd0) begin
      short_to_float = '0;
    end else begin
      short_to_float = sign | ({24'd0, 8'(8'd127 + {3'd0, p})} << 23) | (ms & 32'h007f_ffff);
    end
  endfunction

endpackage

/* rtl/core/cbrd_parser.sv */
module cbrd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_legacy,
  input  logic               in_fire,
  input  logic [7:0]         in_byte,
  input  logic               in_start,
  output logic               cmd_valid,
  output cbrd_pkg::cmd_t     cmd
);
  import cbrd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [31:0] fs_r, fs_nxt;
  logic [31:0] xoff_r, xoff_nxt, yoff_r, yoff_nxt;
  logic        short_r, short_nxt;
  logic [15:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic [31:0] rowb_r, rowb_nxt, hx_r, hx_nxt, items_r, items_nxt;
  logic [15:0] gw_r, gw_nxt, gcol_r, gcol_nxt;

  phase_t      ph;
  logic [31:0] fsa, v, vs16;
  logic [2:0]  flen, posa;
  logic        done, skip;
  logic [15:0] mag, gcol_inc;
  logic [15:0] rows_dec, cols_dec;

  always_comb begin
    ph = in_start ? PH_NREC : phase_r;
    fsa = in_start ? 32'd0 : fs_r;
    posa = in_start ? 3'd0 : pos_r;
    fsa = fsa | ({24'd0, in_byte} << {posa[1:0], 3'b000});
    v = fsa;
    vs16 = {{16{v[15]}}, v[15:0]};
    unique case (ph)
      PH_SHORT, PH_TYPE: flen = 3'd1;
      PH_ROWS, PH_RY, PH_COLS, PH_RX, PH_WIDTH: flen = 3'd2;
      PH_RCNT, PH_GCNT: flen = short_r ? 3'd2 : 3'd4;
      default: flen = 3'd4;
    endcase
    done = (3'(posa + 3'd1) >= flen);
    rows_dec = rows_r - 16'd1;
    cols_dec = cols_r - 16'd1;
    mag = gw_r[15] ? 16'(-gw_r) : gw_r;
    gcol_inc = gcol_r + 16'd1;
    skip = short_r ? (v[15:0] == 16'h8000)
         : (v[30:23] == 8'hff && v[22:0] != 23'd0);

    phase_nxt = ph; pos_nxt = 3'(posa + 3'd1); fs_nxt = fsa;
    xoff_nxt = xoff_r; yoff_nxt = yoff_r; short_nxt = short_r;
    rows_nxt = rows_r; cols_nxt = cols_r; rowb_nxt = rowb_r; hx_nxt = hx_r;
    items_nxt = items_r; gw_nxt = gw_r; gcol_nxt = gcol_r;
    cmd_valid = 1'b0;
    cmd = '0;
    cmd.tail_kind = KIND_END;
    cmd.x = hx_r; cmd.y = rowb_r; cmd.cnt = v; cmd.short_val = v[15:0];

    if (!in_fire || ph == PH_IDLE) begin
      phase_nxt = in_fire ? ph : phase_r;
      pos_nxt = pos_r; fs_nxt = fs_r;
      if (in_fire) begin
        pos_nxt = posa; fs_nxt = in_start ? 32'd0 : fs_r;
      end
    end else if (done) begin
      pos_nxt = '0; fs_nxt = '0;
      unique case (ph)
        PH_NREC: begin
          items_nxt = v;
          if (cfg_legacy) begin
            if (v == 0 || v[31]) begin
              cmd_valid = 1'b1; cmd.tail = 1'b1; phase_nxt = PH_IDLE;
            end else phase_nxt = PH_LX;
          end else phase_nxt = PH_XOFF;
        end
        PH_LX: begin hx_nxt = v; phase_nxt = PH_LY; end
        PH_LY: begin rowb_nxt = v; phase_nxt = PH_LCNT; end
        PH_LCNT: begin
          cmd_valid = 1'b1; cmd.rec = 1'b1;
          items_nxt = items_r - 32'd1;
          if (items_nxt == 0) begin cmd.tail = 1'b1; phase_nxt = PH_IDLE; end
          else phase_nxt = PH_LX;
        end
        PH_XOFF: begin xoff_nxt = v; phase_nxt = PH_YOFF; end
        PH_YOFF: begin yoff_nxt = v; phase_nxt = PH_SHORT; end
        PH_SHORT: begin short_nxt = (v == 0); phase_nxt = PH_TYPE; end
        PH_TYPE: begin
          if (v[7:0] == 8'd1) phase_nxt = PH_ROWS;
          else if (v[7:0] == 8'd2) phase_nxt = PH_NPTS;
          else begin cmd_valid = 1'b1; cmd.tail = 1'b1; phase_nxt = PH_IDLE; end
        end
        PH_ROWS: begin
          rows_nxt = v[15:0];
          if (v[15:0] == 0 || v[15]) begin
            cmd_valid = 1'b1; cmd.tail = 1'b1; phase_nxt = PH_IDLE;
          end else phase_nxt = PH_RY;
        end
        PH_RY: begin rowb_nxt = yoff_r + vs16; phase_nxt = PH_COLS; end
        PH_COLS: begin
          cols_nxt = v[15:0];
          if (v[15:0] == 0 || v[15]) begin
            rows_nxt = rows_dec;
            if (rows_dec == 0) begin
              cmd_valid = 1'b1; cmd.tail = 1'b1; phase_nxt = PH_IDLE;
            end else phase_nxt = PH_RY;
          end else phase_nxt = PH_RX;
        end
        PH_RX: begin hx_nxt = xoff_r + vs16; phase_nxt = PH_RCNT; end
        PH_RCNT: begin
          cmd_valid = 1'b1; cmd.rec = 1'b1; cmd.cnt_short = short_r;
          cols_nxt = cols_dec;
          if (cols_dec == 0) begin
            rows_nxt = rows_dec;
            if (rows_dec == 0) begin cmd.tail = 1'b1; phase_nxt = PH_IDLE; end
            else phase_nxt = PH_RY;
          end else phase_nxt = PH_RX;
        end
        PH_NPTS: begin items_nxt = v; phase_nxt = PH_WIDTH; end
        PH_WIDTH: begin
          gw_nxt = v[15:0];
          if (items_r == 0 || items_r[31]) begin
            cmd_valid = 1'b1; cmd.tail = 1'b1; phase_nxt = PH_IDLE;
          end else if (v[15:0] == 0) begin
            cmd_valid = 1'b1; cmd.tail = 1'b1; cmd.tail_kind = KIND_ERROR;
            phase_nxt = PH_IDLE;
          end else begin
            gcol_nxt = '0; rowb_nxt = yoff_r; phase_nxt = PH_GCNT;
          end
        end
        PH_GCNT: begin
          cmd.rec = !skip; cmd.cnt_short = short_r;
          cmd.x = xoff_r + {16'd0, gcol_r};
          if (gcol_inc >= mag) begin
            gcol_nxt = '0;
            rowb_nxt = gw_r[15] ? rowb_r - 32'd1 : rowb_r + 32'd1;
          end else gcol_nxt = gcol_inc;
          items_nxt = items_r - 32'd1;
          if (items_nxt == 0) begin cmd.tail = 1'b1; phase_nxt = PH_IDLE; end
          cmd_valid = cmd.rec | cmd.tail;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; pos_r <= '0; fs_r <= '0; xoff_r <= '0; yoff_r <= '0;
      short_r <= 1'b0; rows_r <= '0; cols_r <= '0; rowb_r <= '0; hx_r <= '0;
      items_r <= '0; gw_r <= '0; gcol_r <= '0;
    end else begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; fs_r <= fs_nxt;
      xoff_r <= xoff_nxt; yoff_r <= yoff_nxt; short_r <= short_nxt;
      rows_r <= rows_nxt; cols_r <= cols_nxt; rowb_r <= rowb_nxt; hx_r <= hx_nxt;
      items_r <= items_nxt; gw_r <= gw_nxt; gcol_r <= gcol_nxt;
    end
  end
endmodule

/* rtl/core/cbrd_queue.sv */
module cbrd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  cbrd_pkg::cmd_t wr_data,
  output logic [2:0]     level,
  input  logic           rd_en,
  output logic           rd_valid,
  output cbrd_pkg::cmd_t rd_data
);
  import cbrd_pkg::*;

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt = wr_en ? QAW'(wp_r + 1'b1) : wp_r;
    rp_nxt = rd_en ? QAW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
  end

  assign rd_valid = (cnt_r != 0);
  assign rd_data  = mem_r[rp_r];
  assign level    = cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule

/* rtl/core/cbrd_emitter.sv */
module cbrd_emitter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  cbrd_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           res_valid,
  output cbrd_pkg::res_t res,
  input  logic           res_ready
);
  import cbrd_pkg::*;

  logic  half_r, half_nxt;
  logic  val_r, val_nxt;
  res_t  res_r, res_nxt;
  logic  load, second;
  res_t  cur;

  always_comb begin
    second = half_r || !cmd.rec;
    cur = '0;
    if (second) begin
      cur.kind = cmd.tail_kind;
      cur.last = 1'b1;
    end else begin
      cur.kind = KIND_RECORD;
      cur.x = cmd.x;
      cur.y = cmd.y;
      cur.cnt = cmd.cnt_short ? short_to_float(cmd.short_val) : cmd.cnt;
      cur.last = !cmd.tail;
    end
    load = cmd_valid && (!val_r || res_ready);
    cmd_pop = load && (second || !cmd.tail);
    half_nxt = half_r;
    if (load) begin
      half_nxt = !second && cmd.tail;
    end
    val_nxt = load ? 1'b1 : (res_ready ? 1'b0 : val_r);
    res_nxt = load ? cur : res_r;
  end

  assign res_valid = val_r;
  assign res = res_r;

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      half_r <= 1'b0; val_r <= 1'b0;
    end else begin
      half_r <= half_nxt; val_r <= val_nxt;
    end
  end
endmodule

/* rtl/core/contact_block_record_decoder.sv */
// Channel   Dir  Payload
// in_*      in   tdata: data_byte[7:0]; tuser: block_start
// out_*     out  tdata: bin_x, bin_y, count_bits; tuser: result_kind; tlast: last
// cfg_*     in   wdata: legacy_layout
// One byte is taken per cycle while fewer than three commands are queued; the parser
// keeps all field state in registers. A byte that yields a record and a block end
// gives two results, and a four-entry command queue decouples the parser from output
// stalls. Reset is synchronous; after it the parser waits for a block start.
module contact_block_record_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // block_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // bin_x, bin_y, count_bits
  output logic [1:0]  out_tuser,  // result_kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_wdata   // legacy_layout
);
  import cbrd_pkg::*;

  logic       legacy_r;
  logic       in_fire, pv, qv, pop;
  logic [2:0] level;
  cmd_t       pcmd, qcmd;
  res_t       res;

  assign cfg_ready = 1'b1;
  assign in_tready = (level < 3'd3);
  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) legacy_r <= 1'b0;
    else if (cfg_valid) legacy_r <= cfg_wdata;
  end

  cbrd_parser u_parser (
    .clk, .rst_n, .cfg_legacy(legacy_r), .in_fire, .in_byte(in_tdata),
    .in_start(in_tuser), .cmd_valid(pv), .cmd(pcmd)
  );

  cbrd_queue u_queue (
    .clk, .rst_n, .wr_en(pv), .wr_data(pcmd), .level,
    .rd_en(pop), .rd_valid(qv), .rd_data(qcmd)
  );

  cbrd_emitter u_emit (
    .clk, .rst_n, .cmd_valid(qv), .cmd(qcmd), .cmd_pop(pop),
    .res_valid(out_tvalid), .res, .res_ready(out_tready)
  );

  assign out_tdata = {res.cnt, res.y, res.x};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;
endmodule
